[hdl/assert_macros.svh]
// Assertion macros used by the top level of the scanline interrupt timer RTL.
// Each macro samples on the rising edge of clk and is disabled during reset (rst_n low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/vlit_pkg.sv]
// Package for the scanline interrupt timer: configuration and result structs,
// register indexes and fixed line constants. No dependencies.
package vlit_pkg;

    localparam int LINE_W = 9;
    localparam int CNT_W  = 9;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [LINE_W-1:0] NTSC_ACTIVE = 9'd224;
    localparam logic [LINE_W-1:0] PAL_ACTIVE  = 9'd240;
    localparam logic [1:0]        PHASE_LAST  = 2'd2;

    typedef enum logic [2:0] {
        REG_RELOAD    = 3'd0,
        REG_LINE_EN   = 3'd1,
        REG_VBLANK_EN = 3'd2,
        REG_PAL       = 3'd3,
        REG_SKIP_EN   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] reload;
        logic       line_irq_en;
        logic       vblank_irq_en;
        logic       pal;
        logic       skip_en;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              draw;
        logic              hint;
        logic              irq4;
        logic              irq6;
        logic              sub_irq;
        logic              vpend;
        logic              fend;
    } result_t;

endpackage

[hdl/video_line_interrupt_timer.sv]
// Top level of the scanline interrupt timer: configuration port, scanline state
// and the output register. Depends on vlit_pkg, vlit_regs, vlit_line and assert_macros.svh.
//
// Each accepted input transaction is one scanline tick; the block returns exactly one
// result transaction for it, in the next cycle, from an output register. A new
// line is taken in every cycle as long as the output register is empty or is being
// read in the same cycle, so the sustained rate is one line per clock. The whole
// update is a single pass of compares and a counter decrement between the state
// registers and the output register. Configuration is written over the APB-style port
// at byte address 4 times the register index; writes beyond the register list are ignored.
`include "assert_macros.svh"

module video_line_interrupt_timer
    import vlit_pkg::*;
#(
    parameter int NTSC_LINES = 262,
    parameter int PAL_LINES  = 313
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              vblank_ack,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LINE_W-1:0] line_number,
    output logic              draw_line,
    output logic              hint_fire,
    output logic              irq4_request,
    output logic              irq6_request,
    output logic              sub_irq_level,
    output logic              vblank_pending,
    output logic              frame_end
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    step;

    vlit_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vlit_line #(
        .NTSC_LINES (NTSC_LINES),
        .PAL_LINES  (PAL_LINES)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (step),
        .vblank_ack (vblank_ack),
        .res        (res)
    );

    assign in_stall = out_valid_reg & out_stall;
    assign step     = in_valid & ~in_stall;

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_number    = res_reg.line;
    assign draw_line      = res_reg.draw;
    assign hint_fire      = res_reg.hint;
    assign irq4_request   = res_reg.irq4;
    assign irq6_request   = res_reg.irq6;
    assign sub_irq_level  = res_reg.sub_irq;
    assign vblank_pending = res_reg.vpend;
    assign frame_end      = res_reg.fend;

    `ASSERT_NEXT(a_step_loads_output, step, out_valid_reg)
    `ASSERT_IMPL(a_irq4_needs_hint, out_valid_reg && res_reg.irq4, res_reg.hint)
    `ASSERT_IMPL(a_irq6_sets_pending, out_valid_reg && res_reg.irq6, res_reg.vpend && res_reg.sub_irq)

endmodule

[hdl/vlit_regs.sv]
// Configuration register file of the scanline interrupt timer, behind an APB-style port.
// Depends on vlit_pkg for the register indexes and the configuration struct.
module vlit_regs
    import vlit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RELOAD:    cfg_next.reload        = pwdata[7:0];
                REG_LINE_EN:   cfg_next.line_irq_en   = pwdata[0];
                REG_VBLANK_EN: cfg_next.vblank_irq_en = pwdata[0];
                REG_PAL:       cfg_next.pal           = pwdata[0];
                REG_SKIP_EN:   cfg_next.skip_en       = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RELOAD:    prdata = {{(DATA_W-8){1'b0}}, cfg_reg.reload};
            REG_LINE_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.line_irq_en};
            REG_VBLANK_EN: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.vblank_irq_en};
            REG_PAL:       prdata = {{(DATA_W-1){1'b0}}, cfg_reg.pal};
            REG_SKIP_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_reg.skip_en};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/vlit_line.sv]
// Scanline state and next-state logic: line number, line interrupt counter,
// vblank pending flag, secondary interrupt line, draw flag and frame phase.
// Depends on vlit_pkg.
module vlit_line
    import vlit_pkg::*;
#(
    parameter int NTSC_LINES = 262,
    parameter int PAL_LINES  = 313
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  logic    vblank_ack,
    output result_t res
);

    localparam int WIDE_W = LINE_W + 1;
    localparam logic [WIDE_W-1:0] NTSC_TOTAL = WIDE_W'(NTSC_LINES);
    localparam logic [WIDE_W-1:0] PAL_TOTAL  = WIDE_W'(PAL_LINES);

    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              vpend_reg;
    logic              vpend_next;
    logic              sub_reg;
    logic              sub_next;
    logic              draw_reg;
    logic              draw_next;
    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;

    logic [WIDE_W-1:0] total;
    logic [WIDE_W-1:0] height;
    logic [LINE_W-1:0] line;
    logic [WIDE_W-1:0] line_wide;
    logic [WIDE_W-1:0] next_wide;
    logic [CNT_W-1:0]  cnt_start;
    logic [CNT_W-1:0]  reload_wide;
    logic              acked_pend;
    logic              hint;
    logic              irq4;
    logic              irq6;
    logic              fend;

    always_comb
    begin
        total       = cfg.pal ? PAL_TOTAL : NTSC_TOTAL;
        height      = {1'b0, (cfg.pal ? PAL_ACTIVE : NTSC_ACTIVE)};
        reload_wide = {1'b0, cfg.reload};
        acked_pend  = vpend_reg & ~vblank_ack;

        line      = ({1'b0, line_reg} >= total) ? '0 : line_reg;
        line_wide = {1'b0, line};
        next_wide = line_wide + WIDE_W'(1);

        cnt_start = ((line == '0) || (line_wide > height)) ? reload_wide : cnt_reg;

        hint = 1'b0;
        irq4 = 1'b0;
        if (cnt_start == '0)
        begin
            hint     = cfg.line_irq_en & (line_wide <= height);
            irq4     = hint & ~acked_pend;
            cnt_next = reload_wide;
        end
        else
        begin
            cnt_next = cnt_start - CNT_W'(1);
        end

        vpend_next = acked_pend;
        sub_next   = sub_reg;
        draw_next  = draw_reg;
        irq6       = 1'b0;
        if (next_wide == height)
        begin
            if (cfg.vblank_irq_en)
            begin
                vpend_next = 1'b1;
                irq6       = 1'b1;
            end
            sub_next = 1'b1;
        end

        if (!cfg.pal && (next_wide == height + WIDE_W'(1)))
        begin
            sub_next  = 1'b0;
            draw_next = ~cfg.skip_en | (phase_reg != 2'd0);
        end

        fend       = (next_wide >= total);
        phase_next = phase_reg;
        if (fend)
        begin
            phase_next = (phase_reg >= PHASE_LAST) ? 2'd0 : phase_reg + 2'd1;
            line_next  = '0;
        end
        else
        begin
            line_next = next_wide[LINE_W-1:0];
        end

        res.line    = line;
        res.draw    = draw_reg;
        res.hint    = hint;
        res.irq4    = irq4;
        res.irq6    = irq6;
        res.sub_irq = sub_next;
        res.vpend   = vpend_next;
        res.fend    = fend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            cnt_reg   <= '0;
            vpend_reg <= 1'b0;
            sub_reg   <= 1'b0;
            draw_reg  <= 1'b1;
            phase_reg <= 2'd0;
        end
        else if (step)
        begin
            line_reg  <= line_next;
            cnt_reg   <= cnt_next;
            vpend_reg <= vpend_next;
            sub_reg   <= sub_next;
            draw_reg  <= draw_next;
            phase_reg <= phase_next;
        end
    end

endmodule
